FILE: design/mcc_pkg.sv
// package: request and result types, constants and the timing table functions
package mcc_pkg;

   localparam int TotalBits = 20;
   localparam int CycBits   = 7;
   localparam int LoopBits  = 28;

   localparam logic [4:0] FN_MOVE  = 5'd0;
   localparam logic [4:0] FN_MOVEQ = 5'd1;
   localparam logic [4:0] FN_SWAP  = 5'd2;
   localparam logic [4:0] FN_NEG   = 5'd3;
   localparam logic [4:0] FN_NOT   = 5'd4;
   localparam logic [4:0] FN_TST   = 5'd5;
   localparam logic [4:0] FN_CMP   = 5'd6;
   localparam logic [4:0] FN_ADD   = 5'd7;
   localparam logic [4:0] FN_ADDQ  = 5'd8;
   localparam logic [4:0] FN_AND   = 5'd9;
   localparam logic [4:0] FN_EOR   = 5'd10;
   localparam logic [4:0] FN_OR    = 5'd11;
   localparam logic [4:0] FN_SUB   = 5'd12;
   localparam logic [4:0] FN_SUBQ  = 5'd13;
   localparam logic [4:0] FN_MULS  = 5'd14;
   localparam logic [4:0] FN_MULU  = 5'd15;
   localparam logic [4:0] FN_DIVU  = 5'd16;
   localparam logic [4:0] FN_DIVS  = 5'd17;
   localparam logic [4:0] FN_BRA   = 5'd18;
   localparam logic [4:0] FN_DBRA  = 5'd19;
   localparam logic [4:0] FN_LSL   = 5'd20;
   localparam logic [4:0] FN_LSR   = 5'd21;
   localparam logic [4:0] FN_ASL   = 5'd22;
   localparam logic [4:0] FN_ASR   = 5'd23;
   localparam logic [4:0] FN_ROL   = 5'd24;
   localparam logic [4:0] FN_ROR   = 5'd25;

   localparam logic [2:0] MD_DN    = 3'd0;
   localparam logic [2:0] MD_AN    = 3'd1;
   localparam logic [2:0] MD_IND   = 3'd2;
   localparam logic [2:0] MD_POST  = 3'd3;
   localparam logic [2:0] MD_PRE   = 3'd4;
   localparam logic [2:0] MD_DISP  = 3'd5;
   localparam logic [2:0] MD_INDEX = 3'd6;
   localparam logic [2:0] MD_OTHER = 3'd7;

   localparam logic [2:0] RG_ABSW  = 3'd0;
   localparam logic [2:0] RG_ABSL  = 3'd1;
   localparam logic [2:0] RG_PCD   = 3'd2;
   localparam logic [2:0] RG_PCX   = 3'd3;
   localparam logic [2:0] RG_IMM   = 3'd4;

   localparam logic [0:0] REG_UNROLL = 1'b0;

   typedef struct packed {
      logic [4:0] func;
      logic [1:0] operand_count;
      logic       long_size;
      logic [2:0] src_mode;
      logic [2:0] src_reg;
      logic [2:0] dst_mode;
      logic [2:0] dst_reg;
      logic       embedded_immediate;
      logic       last_instruction;
   } req_type;

   typedef struct packed {
      logic [CycBits-1:0]   best_cycles;
      logic [CycBits-1:0]   cache_cycles;
      logic [CycBits-1:0]   worst_cycles;
      logic                 unsupported;
      logic [TotalBits-1:0] sum_best;
      logic [TotalBits-1:0] sum_cache;
      logic [TotalBits-1:0] sum_worst;
      logic [LoopBits-1:0]  loop_cycles;
      logic                 final_result;
   } rsp_type;

   // ok flag plus three counts
   typedef struct packed {
      logic               ok;
      logic [CycBits-1:0] b;
      logic [CycBits-1:0] c;
      logic [CycBits-1:0] w;
   } cost_type;

   function automatic cost_type mk(input int b, input int c, input int w);
      cost_type r;
      r.ok = 1'b1;
      r.b = CycBits'(b);
      r.c = CycBits'(c);
      r.w = CycBits'(w);
      return r;
   endfunction

   function automatic cost_type bad_cost();
      cost_type r;
      r = '0;
      return r;
   endfunction

   function automatic cost_type add_cost(input cost_type a, input cost_type x);
      cost_type r;
      r.ok = a.ok & x.ok;
      r.b = a.b + x.b;
      r.c = a.c + x.c;
      r.w = a.w + x.w;
      return r;
   endfunction

   function automatic cost_type ea_cost(input logic [2:0] m, input logic [2:0] r,
                                        input logic lng);
      cost_type o;
      o = bad_cost();
      case (m)
         MD_DN, MD_AN: o = mk(0, 0, 0);
         MD_IND:   o = mk(3, 4, 4);
         MD_POST:  o = mk(4, 4, 4);
         MD_PRE:   o = mk(3, 5, 5);
         MD_DISP:  o = mk(3, 5, 6);
         MD_INDEX: o = mk(4, 7, 8);
         default: begin
            if (r == RG_ABSW) o = mk(3, 4, 6);
            else if (r == RG_ABSL) o = mk(3, 4, 7);
            else if (r == RG_IMM) o = lng ? mk(0, 4, 5) : mk(0, 2, 3);
         end
      endcase
      return o;
   endfunction

   function automatic cost_type ea_or_emb(input logic [2:0] m, input logic [2:0] r,
                                          input logic lng, input logic emb);
      cost_type o;
      if (m == MD_OTHER && r == RG_IMM && emb) o = mk(0, 0, 0);
      else o = ea_cost(m, r, lng);
      return o;
   endfunction

   function automatic cost_type fiea_cost(input logic [2:0] m_in, input logic [2:0] r,
                                          input logic lng);
      cost_type o;
      logic [2:0] m;
      logic done;
      m = m_in;
      done = 1'b0;
      o = bad_cost();
      if (m == MD_OTHER) begin
         done = 1'b1;
         if (r == RG_PCD) begin
            m = MD_DISP;
            done = 1'b0;
         end else if (r == RG_PCX) begin
            m = MD_INDEX;
            done = 1'b0;
         end else if (r == RG_ABSW) o = lng ? mk(4, 7, 10) : mk(3, 5, 7);
         else if (r == RG_ABSL) o = lng ? mk(4, 8, 12) : mk(3, 6, 10);
         else if (r == RG_IMM) o = lng ? mk(1, 8, 10) : mk(0, 4, 6);
      end
      if (!done) begin
         case (m)
            MD_DN, MD_AN: o = lng ? mk(1, 4, 5) : mk(0, 2, 3);
            MD_IND:  o = lng ? mk(3, 4, 7) : mk(3, 4, 4);
            MD_POST: o = lng ? mk(5, 8, 9) : mk(4, 6, 7);
            MD_PRE:  o = lng ? mk(4, 7, 8) : mk(3, 5, 6);
            MD_DISP: o = lng ? mk(4, 7, 10) : mk(3, 5, 7);
            default: o = lng ? mk(5, 11, 13) : mk(4, 9, 11);
         endcase
      end
      return o;
   endfunction

   function automatic cost_type move_cost(input logic [2:0] sm_in, input logic [2:0] sr,
                                          input logic [2:0] dm, input logic [2:0] dr,
                                          input logic lng);
      cost_type o;
      logic [2:0] sm;
      sm = sm_in;
      o = bad_cost();
      if (sm == MD_OTHER && sr == RG_PCD) sm = MD_DISP;
      else if (sm == MD_OTHER && sr == RG_PCX) sm = MD_INDEX;
      if (sm == MD_OTHER && sr != RG_IMM && sr != RG_PCD && sr != RG_PCX) begin
         o = bad_cost();
      end else if (sm <= MD_AN) begin
         case (dm)
            MD_DN, MD_AN: o = mk(0, 2, 3);
            MD_IND:   o = mk(3, 4, 5);
            MD_POST:  o = mk(4, 4, 5);
            MD_PRE:   o = mk(3, 5, 6);
            MD_DISP:  o = mk(3, 5, 7);
            MD_INDEX: o = mk(4, 7, 9);
            default: begin
               if (dr == RG_ABSW) o = mk(3, 4, 7);
               else if (dr == RG_ABSL) o = mk(5, 6, 9);
            end
         endcase
      end else if (dm == MD_OTHER || sm == MD_POST || sm == MD_PRE) begin
         o = bad_cost();
      end else if (sm == MD_IND) begin
         if (dm <= MD_AN) o = mk(3, 6, 7);
         else if (dm <= MD_PRE) o = mk(6, 7, 9);
         else if (dm == MD_DISP) o = mk(6, 7, 11);
         else o = mk(8, 9, 11);
      end else if (sm == MD_DISP) begin
         if (dm <= MD_AN) o = mk(3, 7, 9);
         else if (dm <= MD_PRE) o = mk(6, 8, 11);
         else if (dm == MD_DISP) o = mk(6, 8, 13);
         else o = mk(8, 10, 13);
      end else if (sm == MD_INDEX) begin
         if (dm <= MD_AN) o = mk(4, 9, 11);
         else if (dm <= MD_PRE) o = mk(7, 10, 13);
         else if (dm == MD_DISP) o = mk(7, 10, 15);
         else o = mk(9, 12, 15);
      end else begin
         // immediate source, table entries kept as published
         case (dm)
            MD_DN, MD_AN: o = lng ? mk(0, 6, 5) : mk(0, 4, 3);
            MD_IND:  o = lng ? mk(3, 8, 7) : mk(3, 6, 5);
            MD_POST: o = lng ? mk(4, 8, 7) : mk(4, 6, 8);
            MD_PRE:  o = lng ? mk(3, 9, 8) : mk(3, 7, 6);
            MD_DISP: o = lng ? mk(3, 9, 9) : mk(3, 7, 7);
            default: o = lng ? mk(4, 9, 11) : mk(4, 7, 9);
         endcase
      end
      return o;
   endfunction

   function automatic cost_type instr_cost(input req_type q);
      cost_type o;
      cost_type t;
      logic simm;
      logic n1;
      logic n2;
      simm = q.operand_count != 2'd0 && q.src_mode == MD_OTHER && q.src_reg == RG_IMM;
      n1 = q.operand_count == 2'd1;
      n2 = q.operand_count == 2'd2;
      o = bad_cost();
      t = mk(0, 0, 0);
      if (q.operand_count != 2'd3) begin
         case (q.func)
            FN_MOVE: if (n2) o = move_cost(q.src_mode, q.src_reg, q.dst_mode,
                                           q.dst_reg, q.long_size);
            FN_MOVEQ: o = mk(0, 2, 3);
            FN_SWAP:  o = mk(1, 4, 4);
            FN_NEG, FN_NOT, FN_TST: begin
               if (n1) begin
                  if (q.src_mode == MD_DN) o = mk(0, 2, 3);
                  else o = add_cost(mk(3, 4, 6), ea_or_emb(q.src_mode, q.src_reg,
                                                           q.long_size,
                                                           q.embedded_immediate));
               end
            end
            FN_CMP, FN_ADD, FN_ADDQ, FN_AND, FN_EOR, FN_OR, FN_SUB, FN_SUBQ: begin
               if (n2 && !(q.func == FN_CMP && (simm || q.dst_mode == MD_AN))) begin
                  if (simm && !q.embedded_immediate)
                     t = fiea_cost(q.dst_mode, q.dst_reg, q.long_size);
                  else
                     t = add_cost(ea_or_emb(q.src_mode, q.src_reg, q.long_size,
                                            q.embedded_immediate),
                                  ea_or_emb(q.dst_mode, q.dst_reg, q.long_size,
                                            q.embedded_immediate));
                  o = add_cost(q.dst_mode <= MD_AN ? mk(0, 2, 3) : mk(3, 4, 6), t);
               end
            end
            FN_MULS, FN_MULU, FN_DIVU, FN_DIVS: begin
               if (q.operand_count != 2'd0) begin
                  if (!q.long_size) begin
                     if (q.func <= FN_MULU) o = mk(25, 27, 28);
                     else if (q.func == FN_DIVU) o = mk(42, 44, 44);
                     else o = mk(54, 56, 57);
                     t = ea_or_emb(q.src_mode, q.src_reg, 1'b0, q.embedded_immediate);
                     if (n2) t = add_cost(t, ea_or_emb(q.dst_mode, q.dst_reg, 1'b0,
                                                       q.embedded_immediate));
                  end else begin
                     if (q.func <= FN_MULU) o = mk(41, 43, 44);
                     else if (q.func == FN_DIVU) o = mk(76, 78, 79);
                     else o = mk(88, 90, 91);
                     t = fiea_cost(q.src_mode, q.src_reg, simm);
                  end
                  o = add_cost(o, t);
               end
            end
            FN_BRA, FN_DBRA: o = mk(3, 6, 9);
            FN_LSL, FN_LSR, FN_ASL, FN_ASR, FN_ROL, FN_ROR: begin
               if (n2 && q.dst_mode == MD_DN && (simm || q.src_mode == MD_DN)) begin
                  if (q.func <= FN_LSR) o = simm ? mk(1, 4, 4) : mk(3, 6, 6);
                  else if (q.func == FN_ASR) o = mk(3, 6, 6);
                  else o = mk(5, 8, 8);
               end
            end
            default: o = bad_cost();
         endcase
      end
      return o;
   endfunction

endpackage

FILE: design/mcc_stream_if.sv
// valid/ready stream interface for requests and results
interface mcc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/m68020_instruction_cycle_cost.sv
// top level: instruction cycle cost lookup with running totals
// One request is taken per clock when the result side keeps up. A request is
// registered in the request stage, looked up in the timing tables and, if
// supported, added to the totals; its result is then registered in the result
// register. The lookup, the saturating adds and the 20x9 loop multiply lie
// between the request register and the result register. unroll_count is written
// over the APB port at byte address 0 and must only change while the block is idle.
module m68020_instruction_cycle_cost (
   input  logic        clock,
   input  logic        reset,
   mcc_stream_if.sink   req,
   mcc_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mcc_pkg::*;

   logic [7:0]           unroll_ff, unroll_in;
   req_type              stage_ff;
   logic                 stage_valid_ff, stage_valid_in;
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   logic [TotalBits-1:0] acc_b_ff, acc_c_ff, acc_w_ff;
   logic [TotalBits-1:0] acc_b_in, acc_c_in, acc_w_in;
   logic [TotalBits-1:0] nb, nc, nw;
   cost_type             cost;
   logic                 adv;
   logic [TotalBits+8:0] prod;

   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, unroll_ff};
   assign unroll_in  = (csr_psel && csr_penable && csr_pwrite
                        && csr_paddr == {REG_UNROLL, 1'b0})
                       ? csr_pwdata[7:0] : unroll_ff;

   // stage moves when the result register is free or being emptied
   assign adv = !out_valid_ff || rsp.ready;
   assign req.ready = adv || !stage_valid_ff;

   function automatic logic [TotalBits-1:0] sat(input logic [TotalBits-1:0] a,
                                                input logic [CycBits-1:0] x);
      logic [TotalBits:0] s;
      s = {1'b0, a} + (TotalBits+1)'(x);
      return s[TotalBits] ? '1 : s[TotalBits-1:0];
   endfunction

   always_comb begin
      cost = instr_cost(stage_ff);
      if (cost.ok) begin
         nb = sat(acc_b_ff, cost.b);
         nc = sat(acc_c_ff, cost.c);
         nw = sat(acc_w_ff, cost.w);
      end else begin
         nb = acc_b_ff;
         nc = acc_c_ff;
         nw = acc_w_ff;
      end
      prod = (TotalBits+9)'(nc) * (TotalBits+9)'({1'b0, unroll_ff} + 9'd1);
      out_in.best_cycles  = cost.ok ? cost.b : '0;
      out_in.cache_cycles = cost.ok ? cost.c : '0;
      out_in.worst_cycles = cost.ok ? cost.w : '0;
      out_in.unsupported  = !cost.ok;
      out_in.sum_best     = nb;
      out_in.sum_cache    = nc;
      out_in.sum_worst    = nw;
      out_in.final_result = stage_ff.last_instruction;
      if (!stage_ff.last_instruction) out_in.loop_cycles = '0;
      else if (prod > (TotalBits+9)'({LoopBits{1'b1}})) out_in.loop_cycles = '1;
      else out_in.loop_cycles = prod[LoopBits-1:0];
      acc_b_in = acc_b_ff;
      acc_c_in = acc_c_ff;
      acc_w_in = acc_w_ff;
      if (stage_valid_ff && adv) begin
         acc_b_in = stage_ff.last_instruction ? '0 : nb;
         acc_c_in = stage_ff.last_instruction ? '0 : nc;
         acc_w_in = stage_ff.last_instruction ? '0 : nw;
      end
      stage_valid_in = (stage_valid_ff && !adv) || (req.valid && req.ready);
      out_valid_in = (stage_valid_ff && adv) || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unroll_ff      <= '0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         acc_b_ff       <= '0;
         acc_c_ff       <= '0;
         acc_w_ff       <= '0;
      end else begin
         unroll_ff      <= unroll_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         acc_b_ff       <= acc_b_in;
         acc_c_ff       <= acc_c_in;
         acc_w_ff       <= acc_w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) stage_ff <= req.payload;
      if (stage_valid_ff && adv) out_ff <= out_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !adv |=> stage_valid_ff)
      else $error("request stage dropped while stalled");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && adv && stage_ff.last_instruction |=> acc_c_ff == '0)
      else $error("totals not cleared after last request");
   a_bad: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.unsupported |-> out_ff.cache_cycles == '0)
      else $error("unsupported result carries a cost");
endmodule
